>>> rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	// operation codes (codes above divide act as compare)
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZDEN = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] a_numerator;
		logic [30:0]        a_denominator;
		logic signed [31:0] b_numerator;
		logic [30:0]        b_denominator;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_numerator;
		logic [30:0]        result_denominator;
		logic [1:0]         status;
		logic               is_greater;
		logic               is_equal;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_COMB,
		ST_SIGN,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/rau_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface rau_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: multiply, combine and sign handling, binary gcd steps, restoring
// division of the numerator and then the denominator by the gcd, and a final
// state to register the result.
// Throughput: one beat at a time, the next taken in the cycle after the result is
// registered; the gcd step count sets it. Zero denominator beats go straight to FIN.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction add/sub/mul/div/compare with gcd reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rau_chan_if.sink   in_ch,
	rau_chan_if.source out_ch
);

	state_t state_q, state_nxt;

	in_item_t           item_q;
	logic               err_q;
	logic signed [63:0] p0_q, p1_q, num_q, den_q;
	logic [63:0]        nm_q, dm_q, u_q, v_q, g_q, quo_q, rem_q;
	logic [5:0]         k_q, cnt_q;
	logic               neg_q, nz_q;
	out_item_t          out_q;
	out_item_t          out_nxt;
	logic               ovalid_q;

	logic               accept, load_out, gcd_done, div_last, err_in;
	logic               is_cmp;
	logic signed [32:0] mx, my;
	logic signed [65:0] prod;
	logic [64:0]        rsh;
	logic               rge;
	logic [63:0]        lim;

	assign is_cmp = item_q.operation[2];
	assign lim    = 64'd1 << (VALUE_WIDTH - 1);

	// input check at accept
	assign err_in = (in_ch.data.a_denominator == '0) || (in_ch.data.b_denominator == '0)
		|| ((in_ch.data.operation == OP_DIV) && (in_ch.data.b_numerator == '0));

	// shared multiplier operand select
	always_comb begin
		mx = {item_q.a_numerator[31], item_q.a_numerator};
		my = signed'({2'b00, item_q.b_denominator});
		case (state_q)
			ST_MUL0: begin
				if (item_q.operation == OP_MUL) my = {item_q.b_numerator[31], item_q.b_numerator};
			end
			ST_MUL1: begin
				mx = {item_q.b_numerator[31], item_q.b_numerator};
				my = signed'({2'b00, item_q.a_denominator});
			end
			ST_MUL2: begin
				mx = signed'({2'b00, item_q.a_denominator});
				if (item_q.operation == OP_DIV) my = {item_q.b_numerator[31], item_q.b_numerator};
			end
			default: begin
			end
		endcase
	end
	assign prod = mx * my;

	// shared subtract/compare for the divider
	assign rsh = {rem_q, quo_q[63]};
	assign rge = rsh >= {1'b0, g_q};

	assign gcd_done = (v_q == '0) || (u_q == '0);
	assign div_last = (cnt_q == 6'd63);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_ch.valid) state_nxt = err_in ? ST_FIN : ST_MUL0;
			ST_MUL0: state_nxt = ST_MUL1;
			ST_MUL1: state_nxt = ST_MUL2;
			ST_MUL2: state_nxt = ST_COMB;
			ST_COMB: state_nxt = ST_SIGN;
			ST_SIGN: state_nxt = ST_GCD;
			ST_GCD:  if (gcd_done) state_nxt = ST_DIVN;
			ST_DIVN: if (div_last) state_nxt = ST_DIVD;
			ST_DIVD: if (div_last) state_nxt = ST_FIN;
			ST_FIN:  if (!ovalid_q || out_ch.ready) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		load_out    = (state_q == ST_FIN) && (!ovalid_q || out_ch.ready);
	end
	assign accept       = in_ch.valid && in_ch.ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = out_q;

	// result beat contents
	always_comb begin
		out_nxt = '0;
		if (err_q) begin
			out_nxt.status = STAT_ZDEN;
		end else begin
			out_nxt.is_greater = is_cmp && nz_q && !neg_q;
			out_nxt.is_equal   = is_cmp && !nz_q;
			if (dm_q >= lim || (neg_q ? nm_q > lim : nm_q >= lim)) begin
				out_nxt.status = STAT_OVF;
			end else begin
				out_nxt.status             = STAT_OK;
				out_nxt.result_numerator   = neg_q ? 32'(-nm_q) : nm_q[31:0];
				out_nxt.result_denominator = dm_q[30:0];
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_ch.data;
			err_q  <= err_in;
		end
		case (state_q)
			ST_MUL0: p0_q <= prod[63:0];
			ST_MUL1: p1_q <= prod[63:0];
			ST_MUL2: den_q <= prod[63:0];
			ST_COMB: begin
				if (item_q.operation == OP_ADD) num_q <= p0_q + p1_q;
				else if (item_q.operation == OP_MUL || item_q.operation == OP_DIV) num_q <= p0_q;
				else num_q <= p0_q - p1_q;
			end
			ST_SIGN: begin
				nz_q  <= (num_q != '0);
				neg_q <= (num_q[63] != den_q[63]) && (num_q != '0);
				nm_q  <= num_q[63] ? 64'(-num_q) : 64'(num_q);
				dm_q  <= den_q[63] ? 64'(-den_q) : 64'(den_q);
				u_q   <= num_q[63] ? 64'(-num_q) : 64'(num_q);
				v_q   <= den_q[63] ? 64'(-den_q) : 64'(den_q);
				k_q   <= '0;
			end
			// one binary gcd step a cycle
			ST_GCD: begin
				if (v_q == '0) begin
					g_q <= u_q << k_q;
				end else if (u_q == '0) begin
					g_q <= v_q << k_q;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 6'd1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
				if (gcd_done) begin
					quo_q <= nm_q;
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			// restoring division, one quotient bit a cycle
			ST_DIVN, ST_DIVD: begin
				if (div_last) begin
					rem_q <= '0;
					cnt_q <= '0;
					if (state_q == ST_DIVN) begin
						nm_q  <= {quo_q[62:0], rge};
						quo_q <= dm_q;
					end else begin
						dm_q <= {quo_q[62:0], rge};
					end
				end else begin
					rem_q <= rge ? 64'(rsh - {1'b0, g_q}) : rsh[63:0];
					quo_q <= {quo_q[62:0], rge};
					cnt_q <= cnt_q + 6'd1;
				end
			end
			default: begin
			end
		endcase

		// result beat
		if (load_out) out_q <= out_nxt;
	end

endmodule
`default_nettype wire
